// File: rtl/sha1_stream_hasher_assert.svh
// Assertion macros for the SHA-1 stream hasher.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTH
`define SHA1SH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SHA1SH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SHA1SH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SHA1SH_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/sha1sh_pkg.sv
// Shared types, constants and round functions of the SHA-1 stream hasher.
// No dependencies; imported by every module of the block.
package sha1sh_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;
   localparam int FILL_W       = $clog2(BLOCK_BYTES);
   localparam int WCNT_W       = $clog2(BLOCK_WORDS);
   localparam int LEN_OFFSET   = 56;
   localparam logic [WCNT_W-1:0] LEN_WORD  = WCNT_W'(LEN_OFFSET / 4);
   localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(BLOCK_WORDS - 1);
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam int ROUNDS = 80;
   localparam int RND_W  = $clog2(ROUNDS + 1);
   localparam logic [RND_W-1:0] FOLD_ROUND = RND_W'(ROUNDS);

   localparam int DIGEST_WORDS = 5;
   localparam int DIDX_W       = 3;
   localparam logic [DIDX_W-1:0] LAST_DIDX = DIDX_W'(DIGEST_WORDS - 1);

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - 32 - DIDX_W;

   typedef logic [31:0] word_type;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic {
      CMD_WORD   = 1'b0,
      CMD_DIGEST = 1'b1
   } cmd_type;

   // One queue entry: a big-endian message word, or a digest request whose
   // bit 0 carries the length overflow flag.
   typedef struct packed {
      cmd_type  kind;
      word_type data;
   } qent_type;

   function automatic word_type h_init(input logic [DIDX_W-1:0] idx);
      word_type v;
      case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         default: v = 32'hC3D2E1F0;
      endcase
      return v;
   endfunction

   function automatic word_type round_k(input logic [RND_W-1:0] rnd);
      word_type v;
      if (rnd < RND_W'(20))      v = 32'h5A827999;
      else if (rnd < RND_W'(40)) v = 32'h6ED9EBA1;
      else if (rnd < RND_W'(60)) v = 32'h8F1BBCDC;
      else                       v = 32'hCA62C1D6;
      return v;
   endfunction

   function automatic word_type round_f(input logic [RND_W-1:0] rnd,
                                        input word_type b,
                                        input word_type c,
                                        input word_type d);
      word_type v;
      if (rnd < RND_W'(20))      v = (b & c) | (~b & d);
      else if (rnd < RND_W'(40)) v = b ^ c ^ d;
      else if (rnd < RND_W'(60)) v = (b & c) | (b & d) | (c & d);
      else                       v = b ^ c ^ d;
      return v;
   endfunction

endpackage

// File: rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher: takes a message one byte per transaction and returns
// its 160-bit SHA-1 digest as five 32-bit words, most significant word first.
// Bytes are packed into words and queued, and a full 64-byte block is
// compressed by one round unit (a load step, 80 rounds and the chain
// update) while the next block loads, so on long messages the round unit
// sets the pace. A finish transaction adds 3 to 18 padding words, one or
// two compressions, then five result transactions; the length overflow
// flag rides on tuser of all five. No memory clearing pass is needed after
// reset. Depends on sha1sh_pkg and the assertion header.
`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [sha1sh_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,                        // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic [sha1sh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast,                        // last_word
   output logic        rsp_tuser                         // [0] length_overflow
);
   import sha1sh_pkg::*;

   logic              q_in_valid;
   logic              q_in_ready;
   qent_type          q_in_ent;
   logic              q_out_valid;
   logic              q_out_ready;
   qent_type          q_out_ent;
   word_type          rsp_word;
   logic [DIDX_W-1:0] rsp_idx;

   sha1sh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .req_byte   (req_tdata),
      .q_valid    (q_in_valid),
      .q_ready    (q_in_ready),
      .q_ent      (q_in_ent)
   );

   sha1sh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_ent   (q_in_ent),
      .pop_valid  (q_out_valid),
      .pop_ready  (q_out_ready),
      .pop_ent    (q_out_ent)
   );

   sha1sh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_out_valid),
      .q_ready   (q_out_ready),
      .q_ent     (q_out_ent),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (rsp_word),
      .rsp_idx   (rsp_idx),
      .rsp_last  (rsp_tlast),
      .rsp_ovf   (rsp_tuser)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_idx, rsp_word};

   `SHA1SH_ASSERT_IMP(a_last_matches_index, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_tdata[34:32] == LAST_DIDX), "tlast does not match word index")
   `SHA1SH_ASSERT_NXT(a_gap_after_digest, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid, "result valid right after the last digest word")
   `SHA1SH_ASSERT_NXT(a_finish_blocks_input, clock, reset, req_tvalid && req_tready && req_tuser,
      !req_tready, "input taken while padding a finished message")

endmodule

// File: rtl/sha1sh_front.sv
// Front end: accepts byte transactions, counts message bits, packs words
// and generates the padding words. Depends on sha1sh_pkg.
module sha1sh_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sha1sh_pkg::op_type req_op,
   input  logic [7:0]         req_byte,
   output logic               q_valid,
   input  logic               q_ready,
   output sha1sh_pkg::qent_type q_ent
);
   import sha1sh_pkg::*;

   typedef enum logic [2:0] {
      ST_DATA,
      ST_PAD,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DIGEST
   } state_type;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [63:0]       bits_ff, bits_in;
   logic              ovf_ff, ovf_in;
   logic [23:0]       acc_ff, acc_in;
   logic [WCNT_W-1:0] nxt_wcnt;
   logic [64:0]       bits_sum;
   word_type          pad_word;

   assign nxt_wcnt = fill_ff[FILL_W-1:2] + 1'b1;
   assign bits_sum = {1'b0, bits_ff} + 65'd8;

   // Close the partial word with the pad byte.
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = {PAD_BYTE, 24'd0};
         2'd1:    pad_word = {acc_ff[7:0], PAD_BYTE, 16'd0};
         2'd2:    pad_word = {acc_ff[15:0], PAD_BYTE, 8'd0};
         default: pad_word = {acc_ff[23:0], PAD_BYTE};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      ovf_in     = ovf_ff;
      acc_in     = acc_ff;
      req_tready = 1'b0;
      q_valid    = 1'b0;
      q_ent.kind = CMD_WORD;
      q_ent.data = '0;
      unique case (state_ff)
         ST_DATA: begin
            req_tready = q_ready;
            q_ent.data = {acc_ff, req_byte};
            if (req_tvalid && q_ready) begin
               if (req_op == OP_ABSORB) begin
                  bits_in = bits_sum[63:0];
                  if (bits_sum[64]) ovf_in = 1'b1;
                  acc_in  = {acc_ff[15:0], req_byte};
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff[1:0] == 2'd3) q_valid = 1'b1;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD, ST_ZERO: begin
            q_valid    = 1'b1;
            q_ent.data = (state_ff == ST_PAD) ? pad_word : '0;
            if (q_ready) begin
               fill_in  = {nxt_wcnt, 2'b00};
               state_in = (nxt_wcnt == LEN_WORD) ? ST_LEN_HI : ST_ZERO;
            end
         end
         ST_LEN_HI: begin
            q_valid    = 1'b1;
            q_ent.data = bits_ff[63:32];
            if (q_ready) state_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            q_valid    = 1'b1;
            q_ent.data = bits_ff[31:0];
            if (q_ready) state_in = ST_DIGEST;
         end
         ST_DIGEST: begin
            q_valid    = 1'b1;
            q_ent.kind = CMD_DIGEST;
            q_ent.data = {31'd0, ovf_ff};
            if (q_ready) begin
               bits_in  = '0;
               ovf_in   = 1'b0;
               fill_in  = '0;
               state_in = ST_DATA;
            end
         end
         default: state_in = ST_DATA;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         fill_ff  <= '0;
         bits_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         ovf_ff   <= ovf_in;
      end
      acc_ff <= acc_in;
   end

endmodule

// File: rtl/sha1sh_fifo.sv
// Short queue of word and digest commands between front and back end.
// Depends on sha1sh_pkg.
module sha1sh_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  sha1sh_pkg::qent_type push_ent,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output sha1sh_pkg::qent_type pop_ent
);
   import sha1sh_pkg::*;

   qent_type        mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [Q_AW:0]   cnt_ff;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (cnt_ff != (Q_AW+1)'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_ent    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_ent;
   end

endmodule

// File: rtl/sha1sh_core.sv
// Back end: block load buffer, message schedule, one-round-per-cycle
// compression, chain value and digest output register. Depends on sha1sh_pkg.
module sha1sh_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  sha1sh_pkg::qent_type q_ent,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sha1sh_pkg::word_type rsp_word,
   output logic [sha1sh_pkg::DIDX_W-1:0] rsp_idx,
   output logic                 rsp_last,
   output logic                 rsp_ovf
);
   import sha1sh_pkg::*;

   word_type          ld_ff [BLOCK_WORDS];
   logic [WCNT_W-1:0] ldcnt_ff;
   logic              ldfull_ff;
   word_type          w_ff [BLOCK_WORDS];
   word_type          a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic              busy_ff;
   word_type          h_ff [DIGEST_WORDS];
   logic              out_valid_ff;
   logic [DIDX_W-1:0] out_idx_ff;
   word_type          out_word_ff;
   logic              out_ovf_ff;

   logic              take_word;
   logic              take_dig;
   logic              start;
   logic              out_done;
   logic [DIDX_W-1:0] out_idx_nx;
   word_type          t_sum;
   word_type          w_mix;
   word_type          w_new;

   assign take_word = q_valid && (q_ent.kind == CMD_WORD) && !ldfull_ff;
   // Digest waits until the final block has been folded into the chain.
   assign take_dig  = q_valid && (q_ent.kind == CMD_DIGEST) && !ldfull_ff &&
                      !busy_ff && !out_valid_ff;
   assign q_ready   = take_word || take_dig;
   assign start     = ldfull_ff && !busy_ff && !out_valid_ff;
   assign out_done  = out_valid_ff && rsp_ready;
   assign out_idx_nx = out_idx_ff + 1'b1;

   assign t_sum = {a_ff[26:0], a_ff[31:27]} + round_f(rnd_ff, b_ff, c_ff, d_ff) +
                  e_ff + round_k(rnd_ff) + w_ff[0];
   assign w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign w_new = {w_mix[30:0], w_mix[31]};

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;
   assign rsp_idx   = out_idx_ff;
   assign rsp_last  = (out_idx_ff == LAST_DIDX);
   assign rsp_ovf   = out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ldcnt_ff     <= '0;
         ldfull_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         rnd_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
         for (int i = 0; i < DIGEST_WORDS; i++) h_ff[i] <= h_init(DIDX_W'(i));
      end else begin
         if (take_word) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) ld_ff[i] <= ld_ff[i+1];
            ld_ff[BLOCK_WORDS-1] <= q_ent.data;
            ldcnt_ff <= ldcnt_ff + 1'b1;
            if (ldcnt_ff == LAST_WORD) ldfull_ff <= 1'b1;
         end

         if (start) begin
            for (int i = 0; i < BLOCK_WORDS; i++) w_ff[i] <= ld_ff[i];
            a_ff      <= h_ff[0];
            b_ff      <= h_ff[1];
            c_ff      <= h_ff[2];
            d_ff      <= h_ff[3];
            e_ff      <= h_ff[4];
            rnd_ff    <= '0;
            busy_ff   <= 1'b1;
            ldfull_ff <= 1'b0;
         end else if (busy_ff) begin
            if (rnd_ff == FOLD_ROUND) begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               busy_ff <= 1'b0;
            end else begin
               a_ff <= t_sum;
               b_ff <= a_ff;
               c_ff <= {b_ff[1:0], b_ff[31:2]};
               d_ff <= c_ff;
               e_ff <= d_ff;
               for (int i = 0; i < BLOCK_WORDS - 1; i++) w_ff[i] <= w_ff[i+1];
               w_ff[BLOCK_WORDS-1] <= w_new;
               rnd_ff <= rnd_ff + 1'b1;
            end
         end

         if (take_dig) begin
            out_valid_ff <= 1'b1;
            out_idx_ff   <= '0;
            out_word_ff  <= h_ff[0];
            out_ovf_ff   <= q_ent.data[0];
         end else if (out_done) begin
            if (out_idx_ff == LAST_DIDX) begin
               // Restart the chain for the next message.
               out_valid_ff <= 1'b0;
               for (int i = 0; i < DIGEST_WORDS; i++) h_ff[i] <= h_init(DIDX_W'(i));
            end else begin
               out_idx_ff  <= out_idx_nx;
               out_word_ff <= h_ff[out_idx_nx];
            end
         end
      end
   end

endmodule

// File: tb/sv/sha1_digest_checker.sv
`timescale 1ns / 1ps
// Checker for the SHA-1 stream hasher: watches both stream channels, keeps
// its own SHA-1 state, and compares every digest word. Depends on sha1sh_pkg.
module sha1_digest_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [sha1sh_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                              req_tuser,   // [0] operation
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] digest_word, [34:32] word_index
   input  logic [sha1sh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              rsp_tlast,   // last_word
   input  logic                              rsp_tuser,   // [0] length_overflow
   output int                                fail_count,
   output int                                pending_words
);
   import sha1sh_pkg::*;

   typedef struct packed {
      word_type          word;
      logic [DIDX_W-1:0] idx;
      logic              last;
      logic              ovf;
   } digest_word_type;

   digest_word_type digest_q[$];

   word_type    chain_h [DIGEST_WORDS];
   logic [7:0]  blk [BLOCK_BYTES];
   int unsigned blk_fill;
   logic [63:0] msg_bits;
   logic        len_ovf;
   int          errors;

   function automatic word_type rol(input word_type x, input int unsigned s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void clear_state();
      chain_h[0] = 32'h67452301;
      chain_h[1] = 32'hEFCDAB89;
      chain_h[2] = 32'h98BADCFE;
      chain_h[3] = 32'h10325476;
      chain_h[4] = 32'hC3D2E1F0;
      blk_fill   = 0;
      msg_bits   = '0;
      len_ovf    = 1'b0;
   endfunction

   // Fold the 64-byte block into the chain value with the 80-round schedule.
   function automatic void fold_block();
      word_type w [80];
      word_type a, b, c, d, e, f, k, t;
      int       i;
      for (i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] data);
      logic carry;
      {carry, msg_bits} = {1'b0, msg_bits} + 65'd8;
      if (carry) len_ovf = 1'b1;
      blk[blk_fill] = data;
      blk_fill++;
      if (blk_fill == BLOCK_BYTES) begin
         fold_block();
         blk_fill = 0;
      end
   endfunction

   // Pad, fold the closing block(s) and queue the five digest words.
   function automatic void finish_message();
      digest_word_type dw;
      int              i;
      blk[blk_fill] = PAD_BYTE;
      blk_fill++;
      if (blk_fill > LEN_OFFSET) begin
         while (blk_fill < BLOCK_BYTES) begin
            blk[blk_fill] = 8'h00;
            blk_fill++;
         end
         fold_block();
         blk_fill = 0;
      end
      while (blk_fill < LEN_OFFSET) begin
         blk[blk_fill] = 8'h00;
         blk_fill++;
      end
      for (i = 0; i < 8; i++)
         blk[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
      fold_block();
      for (i = 0; i < DIGEST_WORDS; i++) begin
         dw.word = chain_h[i];
         dw.idx  = DIDX_W'(i);
         dw.last = (i == DIGEST_WORDS - 1);
         dw.ovf  = len_ovf;
         digest_q.push_back(dw);
      end
      clear_state();
   endfunction

   function automatic void report(input string field, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: digest %s mismatch: expected %h, got %h", $time, field,
                  exp_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      digest_word_type dw;
      if (reset) begin
         clear_state();
         digest_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (op_type'(req_tuser) == OP_FINISH) finish_message();
            else absorb_byte(req_tdata[7:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest transaction: expected none, got %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               dw = digest_q.pop_front();
               report("word", dw.word, rsp_tdata[31:0]);
               report("index", 32'(dw.idx), 32'(rsp_tdata[34:32]));
               report("pad", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:35]));
               report("last", 32'(dw.last), 32'(rsp_tlast));
               report("overflow", 32'(dw.ovf), 32'(rsp_tuser));
            end
         end
      end
      fail_count    <= errors;
      pending_words <= digest_q.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the SHA-1 stream hasher testbench: clock, reset, message stimulus
// and receiver stalls. Depends on sha1sh_pkg, the block and sha1_digest_checker.
module tb_top;
   import sha1sh_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 250;
   localparam int HOLD_CYCLES  = 300;
   localparam int ITEM_TARGET  = 160;
   localparam int MSG_TARGET   = 9;

   localparam int PAT_RANDOM = 0;
   localparam int PAT_ZERO   = 1;
   localparam int PAT_ONES   = 2;
   localparam int PAT_ASCII  = 3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] data_byte
   logic                  req_tuser;   // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] digest_word, [34:32] word_index
   logic                  rsp_tlast;   // last_word
   logic                  rsp_tuser;   // [0] length_overflow
   int                    fail_count;
   int                    pending_words;
   int                    items_sent;
   int                    finishes_sent;
   int                    cycle_count;
   bit                    steady;

   sha1_stream_hasher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   sha1_digest_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input op_type op, input logic [7:0] data);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Send len absorb bytes, then a finish carrying a junk byte.
   task automatic send_message(input int len, input int pattern);
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         case (pattern)
            PAT_ZERO:  b = 8'h00;
            PAT_ONES:  b = 8'hFF;
            PAT_ASCII: b = 8'h61 + 8'(i);
            default:   b = 8'($urandom);
         endcase
         send_item(OP_ABSORB, b);
      end
      send_item(OP_FINISH, 8'($urandom));
      finishes_sent++;
   endtask

   initial begin
      int r;
      int len;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= OP_ABSORB;
      items_sent    = 0;
      finishes_sent = 0;
      steady        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty messages back to back, single extreme bytes, "abc", all ones.
      send_message(0, PAT_RANDOM);
      send_message(0, PAT_RANDOM);
      send_message(1, PAT_ZERO);
      send_message(1, PAT_ONES);
      send_message(3, PAT_ASCII);
      send_message(4, PAT_ONES);

      // Padding spills into an extra block, full block.
      send_message(56, PAT_RANDOM);
      send_message(64, PAT_RANDOM);

      while (items_sent < ITEM_TARGET || finishes_sent < MSG_TARGET) begin
         steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = $urandom_range(0, 12);
         end else if (r < 90) begin
            case ($urandom_range(0, 4))
               0:       len = 55;
               1:       len = 56;
               2:       len = 63;
               3:       len = 64;
               default: len = 65;
            endcase
         end else begin
            len = $urandom_range(13, 54);
         end
         send_message(len, PAT_RANDOM);
      end
      req_tvalid <= 1'b0;

      // Let the checker register the last transaction before polling it.
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hold off the first digest long enough for the block to back up its input.
   initial begin
      int run;
      int gap;
      rsp_tready <= 1'b0;
      while (reset || !rsp_tvalid) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80)
                                            : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
